[rtl/query_id_remap_timeout_table_unit_assert.svh]
// Assertion macros for the relay ID remap table.
// Depends on nothing; included by the top level.
`ifndef QUERY_ID_REMAP_TIMEOUT_TABLE_UNIT_ASSERT_SVH
`define QUERY_ID_REMAP_TIMEOUT_TABLE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define QRT_ASSERT_NOW(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("qrt check failed");
`define QRT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qrt check failed");
`else
`define QRT_ASSERT_NOW(label, clk, rst_n, prop)
`define QRT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/qrt_pkg.sv]
// Shared constants, codes and types of the relay ID remap table.
// No dependencies.
package qrt_pkg;

    localparam int ENTRIES       = 32;
    localparam int IDX_W         = $clog2(ENTRIES);
    localparam int WHEEL_SLOTS   = 5;
    localparam int SLOT_W        = 3;
    localparam int MAX_RESOLVERS = 8;
    localparam int CNT_W         = 4;
    localparam int RES_W         = 3;
    localparam logic [15:0] MIN_REPLY_LEN = 16'd12;

    typedef enum logic [1:0] {
        CMD_QUERY = 2'd0,
        CMD_REPLY = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_STALE = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        KIND_FORWARD = 3'd0,
        KIND_DELIVER = 3'd1,
        KIND_DROPPED = 3'd2,
        KIND_EXPIRED = 3'd3,
        KIND_ORPHAN  = 3'd4,
        KIND_SHORT   = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_DELIVER,
        ST_WALK_RD,
        ST_WALK_WR
    } state_t;

    typedef struct packed {
        logic [15:0]      relay_id;
        logic [15:0]      query_id;
        logic [15:0]      handle;
        logic [RES_W-1:0] resolver;
    } entry_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        entry_t           wdata;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } mem_req_t;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] idx;
    } sel_t;

    // lowest set bit
    function automatic sel_t first_set(input logic [ENTRIES-1:0] v);
        sel_t r;
        r = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (v[i]) begin
                r.found = 1'b1;
                r.idx   = IDX_W'(i);
            end
        end
        return r;
    endfunction

endpackage

[rtl/qrt_if.sv]
// Request and result channel interfaces of the relay ID remap table.
// No dependencies.
interface qrt_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [15:0] query_id;
    logic [15:0] client_handle;
    logic [15:0] reply_id;
    logic [15:0] reply_length;
    modport source (output valid, cmd, query_id, client_handle, reply_id, reply_length,
                    input ready);
    modport sink   (input valid, cmd, query_id, client_handle, reply_id, reply_length,
                    output ready);
endinterface

interface qrt_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [15:0] relay_id;
    logic [15:0] orig_id;
    logic [15:0] handle_out;
    logic [2:0]  resolver_index;
    logic        last;
    modport source (output valid, kind, relay_id, orig_id, handle_out, resolver_index, last,
                    input ready);
    modport sink   (input valid, kind, relay_id, orig_id, handle_out, resolver_index, last,
                    output ready);
endinterface

[rtl/qrt_mem.sv]
// Entry store: one write port, one read port, registered read data.
// Depends on qrt_pkg.
module qrt_mem
    import qrt_pkg::*;
(
    input  logic     clk,
    input  mem_req_t req,
    output entry_t   rdata
);

    entry_t mem [ENTRIES];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata <= mem[req.raddr];
        end
    end

endmodule

[rtl/query_id_remap_timeout_table_unit.sv]
// Top level of the relay ID remap table with timeout wheel.
// Depends on qrt_pkg, qrt_if, qrt_mem and the assertion header.
//
// Usage: requests enter on req (valid/ready); each gives zero or more results
// on rsp (valid/ready), the final one flagged by last. cfg_we/cfg_wdata set
// the resolver count; the user must write it only while the block is idle,
// as the block itself does not enforce this. A query or a short reply is
// handled in the accepting cycle; its result sits in the output register
// from the next cycle. A reply that is looked up passes through the match
// vector, then the priority pick and entry read, then the result; an orphan
// is known at the priority pick. A tick handles each entry in the new wheel
// slot in turn (entry read, then retry with write-back, or expiry); a stale
// mark and a tick on an empty table are handled in the accepting cycle.
// Throughput is one request at a time: req waits until the control sequence
// is back in idle.
// Reset clears valid bits, the wheel slot, the relay ID counter and the
// resolver count at once; no clearing pass. While rsp is stalled the output
// register holds its result and the block waits before loading the next one;
// req is ready only in idle with the output register free or being emptied.
`include "query_id_remap_timeout_table_unit_assert.svh"
module query_id_remap_timeout_table_unit
    import qrt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [3:0]   cfg_wdata,
    qrt_req_if.sink      req,
    qrt_rsp_if.source    rsp
);

    state_t               state_reg, state_next;
    logic [ENTRIES-1:0]   valid_reg, valid_next;
    logic [ENTRIES-1:0]   stale_reg, stale_next;
    logic [ENTRIES-1:0]   mask_reg, mask_next;
    logic [SLOT_W-1:0]    cur_slot_reg, cur_slot_next;
    logic [15:0]          next_id_reg, next_id_next;
    logic [15:0]          rid_reg, rid_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [CNT_W-1:0]     rcount_reg;

    // per-entry slot and relay ID for parallel matching
    logic [SLOT_W-1:0]    slot_reg [ENTRIES];
    logic [15:0]          cam_reg  [ENTRIES];

    logic                 out_valid_reg;
    kind_t                out_kind_reg;
    logic [15:0]          out_rid_reg, out_oid_reg, out_hdl_reg;
    logic [RES_W-1:0]     out_res_reg;
    logic                 out_last_reg;

    logic                 load;
    kind_t                ld_kind;
    logic [15:0]          ld_rid, ld_oid, ld_hdl;
    logic [RES_W-1:0]     ld_res;
    logic                 ld_last;

    logic                 alloc_en;
    mem_req_t             mreq;
    entry_t               rdata;

    logic                 out_free;
    logic [CNT_W-1:0]     eff_cnt;
    logic [SLOT_W-1:0]    new_slot;
    logic [ENTRIES-1:0]   match_now, tick_mask;
    sel_t                 free_sel, pick;
    logic [CNT_W-1:0]     nxt;

    qrt_mem u_mem (
        .clk   (clk),
        .req   (mreq),
        .rdata (rdata)
    );

    assign out_free = !out_valid_reg || rsp.ready;
    assign eff_cnt  = (rcount_reg > CNT_W'(MAX_RESOLVERS)) ? CNT_W'(MAX_RESOLVERS) : rcount_reg;
    assign new_slot = (cur_slot_reg == SLOT_W'(WHEEL_SLOTS - 1)) ? '0
                                                                 : cur_slot_reg + 1'b1;
    assign free_sel = first_set(~valid_reg);
    assign pick     = first_set(mask_reg);
    assign nxt      = {1'b0, rdata.resolver} + 1'b1;

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            match_now[i] = valid_reg[i] && (cam_reg[i] == req.reply_id);
            tick_mask[i] = valid_reg[i] && (slot_reg[i] == new_slot);
        end
    end

    assign req.ready = (state_reg == ST_IDLE) && out_free;

    always_comb
    begin
        state_next    = state_reg;
        valid_next    = valid_reg;
        stale_next    = stale_reg;
        mask_next     = mask_reg;
        cur_slot_next = cur_slot_reg;
        next_id_next  = next_id_reg;
        rid_next      = rid_reg;
        idx_next      = idx_reg;
        alloc_en      = 1'b0;
        mreq          = '0;
        load          = 1'b0;
        ld_kind       = KIND_FORWARD;
        ld_rid        = '0;
        ld_oid        = '0;
        ld_hdl        = '0;
        ld_res        = '0;
        ld_last       = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid && req.ready)
                begin
                    case (cmd_t'(req.cmd))
                        CMD_QUERY:
                        begin
                            load   = 1'b1;
                            ld_oid = req.query_id;
                            ld_hdl = req.client_handle;
                            if (eff_cnt == '0 || !free_sel.found)
                            begin
                                ld_kind = KIND_DROPPED;
                            end
                            else
                            begin
                                ld_kind                 = KIND_FORWARD;
                                ld_rid                  = next_id_reg;
                                alloc_en                = 1'b1;
                                valid_next[free_sel.idx] = 1'b1;
                                stale_next[free_sel.idx] = 1'b0;
                                mreq.we                 = 1'b1;
                                mreq.waddr              = free_sel.idx;
                                mreq.wdata.relay_id     = next_id_reg;
                                mreq.wdata.query_id     = req.query_id;
                                mreq.wdata.handle       = req.client_handle;
                                mreq.wdata.resolver     = '0;
                                next_id_next            = next_id_reg + 1'b1;
                            end
                        end
                        CMD_REPLY:
                        begin
                            if (req.reply_length < MIN_REPLY_LEN)
                            begin
                                load    = 1'b1;
                                ld_kind = KIND_SHORT;
                                ld_rid  = req.reply_id;
                            end
                            else
                            begin
                                mask_next  = match_now;
                                rid_next   = req.reply_id;
                                state_next = ST_LOOKUP;
                            end
                        end
                        CMD_TICK:
                        begin
                            if (|valid_reg)
                            begin
                                cur_slot_next = new_slot;
                                mask_next     = tick_mask;
                                state_next    = ST_WALK_RD;
                            end
                        end
                        default:
                        begin
                            stale_next = stale_reg | valid_reg;
                        end
                    endcase
                end
            end
            ST_LOOKUP:
            begin
                if (!pick.found)
                begin
                    if (out_free)
                    begin
                        load       = 1'b1;
                        ld_kind    = KIND_ORPHAN;
                        ld_rid     = rid_reg;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    mreq.re              = 1'b1;
                    mreq.raddr           = pick.idx;
                    valid_next[pick.idx] = 1'b0;
                    state_next           = ST_DELIVER;
                end
            end
            ST_DELIVER:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    ld_kind    = KIND_DELIVER;
                    ld_rid     = rid_reg;
                    ld_oid     = rdata.query_id;
                    ld_hdl     = rdata.handle;
                    ld_res     = rdata.resolver;
                    state_next = ST_IDLE;
                end
            end
            ST_WALK_RD:
            begin
                // only empty on the first visit: the slot had nothing
                if (!pick.found)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    mreq.re             = 1'b1;
                    mreq.raddr          = pick.idx;
                    idx_next            = pick.idx;
                    mask_next[pick.idx] = 1'b0;
                    state_next          = ST_WALK_WR;
                end
            end
            ST_WALK_WR:
            begin
                if (out_free)
                begin
                    load    = 1'b1;
                    ld_rid  = rdata.relay_id;
                    ld_oid  = rdata.query_id;
                    ld_hdl  = rdata.handle;
                    ld_last = (mask_reg == '0);
                    if (stale_reg[idx_reg] || nxt >= eff_cnt)
                    begin
                        ld_kind             = KIND_EXPIRED;
                        valid_next[idx_reg] = 1'b0;
                    end
                    else
                    begin
                        ld_kind             = KIND_FORWARD;
                        ld_res              = nxt[RES_W-1:0];
                        mreq.we             = 1'b1;
                        mreq.waddr          = idx_reg;
                        mreq.wdata          = rdata;
                        mreq.wdata.resolver = nxt[RES_W-1:0];
                    end
                    state_next = (mask_reg == '0) ? ST_IDLE : ST_WALK_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            stale_reg     <= '0;
            mask_reg      <= '0;
            cur_slot_reg  <= '0;
            next_id_reg   <= '0;
            rcount_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            valid_reg    <= valid_next;
            stale_reg    <= stale_next;
            mask_reg     <= mask_next;
            cur_slot_reg <= cur_slot_next;
            next_id_reg  <= next_id_next;
            if (cfg_we)
            begin
                rcount_reg <= cfg_wdata;
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        rid_reg <= rid_next;
        idx_reg <= idx_next;
        if (alloc_en)
        begin
            slot_reg[free_sel.idx] <= cur_slot_reg;
            cam_reg[free_sel.idx]  <= next_id_reg;
        end
        if (load)
        begin
            out_kind_reg <= ld_kind;
            out_rid_reg  <= ld_rid;
            out_oid_reg  <= ld_oid;
            out_hdl_reg  <= ld_hdl;
            out_res_reg  <= ld_res;
            out_last_reg <= ld_last;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.kind           = out_kind_reg;
    assign rsp.relay_id       = out_rid_reg;
    assign rsp.orig_id        = out_oid_reg;
    assign rsp.handle_out     = out_hdl_reg;
    assign rsp.resolver_index = out_res_reg;
    assign rsp.last           = out_last_reg;

    // a result never overwrites one that is still waiting
    `QRT_ASSERT_NOW(a_no_overwrite, clk, rst_n, !load || !out_valid_reg || rsp.ready)
    // a looked-up hit leaves the table on the next cycle
    `QRT_ASSERT_NEXT(a_hit_removed, clk, rst_n, state_reg == ST_LOOKUP && pick.found,
        !valid_reg[$past(pick.idx)] && state_reg == ST_DELIVER)
    // entries still to walk are live
    `QRT_ASSERT_NOW(a_walk_live, clk, rst_n,
        !(state_reg == ST_WALK_RD || state_reg == ST_WALK_WR) || ((mask_reg & ~valid_reg) == '0))
    // wheel slot stays inside the wheel
    `QRT_ASSERT_NOW(a_slot_range, clk, rst_n, cur_slot_reg < SLOT_W'(WHEEL_SLOTS))

endmodule

[verif/qrt_checker.sv]
// Checker for the relay ID remap table: watches both channels, predicts results and compares.
// Depends on qrt_pkg and qrt_if.
`timescale 1ns / 100ps
module qrt_checker
    import qrt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_wdata,
    qrt_req_if          req,
    qrt_rsp_if          rsp,
    output int          fail_count,
    output int          pending,
    output logic [15:0] next_id
);
    typedef struct {
        kind_t       kind;
        logic [15:0] relay_id;
        logic [15:0] orig_id;
        logic [15:0] handle;
        logic [2:0]  res;
        logic        last;
    } result_t;

    result_t     awaited[$];
    logic [3:0]  res_count;
    logic        live   [ENTRIES];
    logic [15:0] e_rid  [ENTRIES];
    logic [15:0] e_cid  [ENTRIES];
    logic [15:0] e_hdl  [ENTRIES];
    logic [2:0]  e_res  [ENTRIES];
    logic        e_stale[ENTRIES];
    logic [2:0]  e_slot [ENTRIES];
    logic [2:0]  slot;

    assign pending = awaited.size();

    function automatic result_t mk(kind_t k, logic [15:0] r, logic [15:0] o,
                                   logic [15:0] h, logic [2:0] x);
        result_t t;
        t.kind = k; t.relay_id = r; t.orig_id = o; t.handle = h; t.res = x; t.last = 1'b0;
        return t;
    endfunction

    task automatic predict_request(cmd_t c, logic [15:0] cid, logic [15:0] hdl,
                                   logic [15:0] rid, logic [15:0] rlen);
        result_t batch[$];
        int      hit;
        int      cnt;
        logic    any;
        hit = -1;
        any = 1'b0;
        cnt = (res_count > MAX_RESOLVERS) ? MAX_RESOLVERS : res_count;
        case (c)
            CMD_QUERY:
            begin
                for (int i = 0; i < ENTRIES; i++)
                    if (!live[i] && hit < 0) hit = i;
                if (cnt == 0 || hit < 0)
                    batch.push_back(mk(KIND_DROPPED, 16'd0, cid, hdl, 3'd0));
                else
                begin
                    live[hit] = 1'b1; e_rid[hit] = next_id; e_cid[hit] = cid;
                    e_hdl[hit] = hdl; e_res[hit] = 3'd0; e_stale[hit] = 1'b0;
                    e_slot[hit] = slot;
                    batch.push_back(mk(KIND_FORWARD, next_id, cid, hdl, 3'd0));
                    next_id = next_id + 16'd1;
                end
            end
            CMD_REPLY:
            begin
                if (rlen < MIN_REPLY_LEN)
                    batch.push_back(mk(KIND_SHORT, rid, 16'd0, 16'd0, 3'd0));
                else
                begin
                    for (int i = 0; i < ENTRIES; i++)
                        if (live[i] && e_rid[i] == rid && hit < 0) hit = i;
                    if (hit < 0)
                        batch.push_back(mk(KIND_ORPHAN, rid, 16'd0, 16'd0, 3'd0));
                    else
                    begin
                        live[hit] = 1'b0;
                        batch.push_back(mk(KIND_DELIVER, rid, e_cid[hit], e_hdl[hit],
                                           e_res[hit]));
                    end
                end
            end
            CMD_TICK:
            begin
                for (int i = 0; i < ENTRIES; i++)
                    if (live[i]) any = 1'b1;
                if (any)
                begin
                    slot = (slot + 3'd1 >= WHEEL_SLOTS) ? 3'd0 : slot + 3'd1;
                    for (int i = 0; i < ENTRIES; i++)
                    begin
                        if (live[i] && e_slot[i] == slot)
                        begin
                            if (e_stale[i] || int'(e_res[i]) + 1 >= cnt)
                            begin
                                live[i] = 1'b0;
                                batch.push_back(mk(KIND_EXPIRED, e_rid[i], e_cid[i],
                                                   e_hdl[i], 3'd0));
                            end
                            else
                            begin
                                e_res[i] = e_res[i] + 3'd1;
                                batch.push_back(mk(KIND_FORWARD, e_rid[i], e_cid[i],
                                                   e_hdl[i], e_res[i]));
                            end
                        end
                    end
                end
            end
            default:
                for (int i = 0; i < ENTRIES; i++)
                    if (live[i]) e_stale[i] = 1'b1;
        endcase
        if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
        foreach (batch[i]) awaited.push_back(batch[i]);
    endtask

    task automatic compare_result();
        result_t t;
        if (awaited.size() == 0)
        begin
            $error("unexpected result kind %0d relay_id %h", rsp.kind, rsp.relay_id);
            fail_count++;
            return;
        end
        t = awaited.pop_front();
        if (rsp.kind !== t.kind)
        begin
            $error("kind: expected %0d, got %0d", t.kind, rsp.kind); fail_count++;
        end
        if (rsp.relay_id !== t.relay_id)
        begin
            $error("relay_id: expected %h, got %h", t.relay_id, rsp.relay_id); fail_count++;
        end
        if (rsp.orig_id !== t.orig_id)
        begin
            $error("orig_id: expected %h, got %h", t.orig_id, rsp.orig_id); fail_count++;
        end
        if (rsp.handle_out !== t.handle)
        begin
            $error("handle_out: expected %h, got %h", t.handle, rsp.handle_out); fail_count++;
        end
        if (rsp.resolver_index !== t.res)
        begin
            $error("resolver_index: expected %0d, got %0d", t.res, rsp.resolver_index);
            fail_count++;
        end
        if (rsp.last !== t.last)
        begin
            $error("last: expected %0d, got %0d", t.last, rsp.last); fail_count++;
        end
    endtask

    initial fail_count = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_count = '0;
            slot      = '0;
            next_id   = '0;
            for (int i = 0; i < ENTRIES; i++) live[i] = 1'b0;
        end
        else
        begin
            if (rsp.valid === 1'b1 && rsp.ready === 1'b1) compare_result();
            if (req.valid === 1'b1 && req.ready === 1'b1)
                predict_request(cmd_t'(req.cmd), req.query_id, req.client_handle,
                                req.reply_id, req.reply_length);
            if (cfg_we) res_count = cfg_wdata;
        end
    end
endmodule

[verif/tb_top.sv]
// Top of the relay ID remap table testbench: clock, reset, request stimulus and verdict.
// Depends on qrt_pkg, qrt_if, the block and qrt_checker.
`timescale 1ns / 100ps
module tb_top;
    import qrt_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [3:0]  cfg_wdata;
    int          fail_count;
    int          pending;
    logic [15:0] next_id;
    int          tx_idle_pct;   // sender gap rate, percent
    int          rx_idle_pct;   // receiver stall rate, percent

    qrt_req_if req_ch();
    qrt_rsp_if rsp_ch();

    query_id_remap_timeout_table_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch.sink),
        .rsp       (rsp_ch.source)
    );

    qrt_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .fail_count (fail_count),
        .pending    (pending),
        .next_id    (next_id)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Result side: random stalls at the current rate, one assignment per edge.
    initial rsp_ch.ready = 1'b0;
    always @(posedge clk)
        rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);

    // Present one request, with an optional gap first, and hold until accepted.
    task automatic send(cmd_t c, logic [15:0] cid, logic [15:0] hdl,
                        logic [15:0] rid, logic [15:0] rlen);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.cmd           <= c;
        req_ch.query_id      <= cid;
        req_ch.client_handle <= hdl;
        req_ch.reply_id      <= rid;
        req_ch.reply_length  <= rlen;
        @(posedge clk);
        while (req_ch.ready !== 1'b1) @(posedge clk);
    endtask

    // Drop valid, let every awaited result come out, then cover the longest
    // silent walk before touching the register.
    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (2 * ENTRIES + 16) @(posedge clk);
    endtask

    task automatic set_resolvers(logic [3:0] n);
        cfg_we    <= 1'b1;
        cfg_wdata <= n;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // Random request mix: mostly queries and replies aimed at recently issued relay IDs.
    task automatic random_request();
        int          p;
        logic [15:0] rid;
        logic [15:0] rlen;
        p = $urandom_range(99);
        rid  = ($urandom_range(9) < 8) ? next_id - 16'($urandom_range(1, 40))
                                       : 16'($urandom);
        rlen = ($urandom_range(9) < 8) ? 16'($urandom_range(12, 65535))
                                       : 16'($urandom_range(0, 13));
        if (p < 45)
            send(CMD_QUERY, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        else if (p < 82)
            send(CMD_REPLY, 16'($urandom), 16'($urandom), rid, rlen);
        else if (p < 96)
            send(CMD_TICK, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        else
            send(CMD_STALE, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        req_ch.valid  = 1'b0;
        req_ch.cmd    = CMD_QUERY;
        req_ch.query_id      = '0;
        req_ch.client_handle = '0;
        req_ch.reply_id      = '0;
        req_ch.reply_length  = '0;
        tx_idle_pct   = 0;
        rx_idle_pct   = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: no resolvers drops a query; empty tick does nothing.
        send(CMD_QUERY, 16'hFFFF, 16'h0000, 16'h0, 16'h0);
        send(CMD_TICK, 16'h0, 16'h0, 16'h0, 16'h0);
        drain();
        set_resolvers(4'd8);
        send(CMD_QUERY, 16'h0000, 16'hFFFF, 16'h0, 16'h0);
        send(CMD_QUERY, 16'hFFFF, 16'h0000, 16'h0, 16'h0);
        send(CMD_REPLY, 16'h0, 16'h0, 16'h0000, 16'd11);     // short, below limit
        send(CMD_REPLY, 16'h0, 16'h0, 16'hFFFF, 16'd0);
        send(CMD_REPLY, 16'h0, 16'h0, 16'h0000, 16'd12);     // exact minimum, hit
        send(CMD_REPLY, 16'h0, 16'h0, 16'h0000, 16'hFFFF);   // orphan now
        // Retries on later resolvers, then a stale mark forces expiry.
        repeat (6) send(CMD_TICK, 16'h0, 16'h0, 16'h0, 16'h0);
        send(CMD_STALE, 16'h0, 16'h0, 16'h0, 16'h0);
        send(CMD_REPLY, 16'h0, 16'h0, 16'h0001, 16'd100);    // stale still delivered
        send(CMD_QUERY, 16'h1234, 16'h5678, 16'h0, 16'h0);
        send(CMD_STALE, 16'h0, 16'h0, 16'h0, 16'h0);
        repeat (5) send(CMD_TICK, 16'h0, 16'h0, 16'h0, 16'h0);
        // Full table: the overflow query is dropped.
        repeat (ENTRIES + 1) send(CMD_QUERY, 16'($urandom), 16'($urandom), 16'h0, 16'h0);
        drain();
        // Shrunk count expires on the next timeout; oversized count saturates.
        set_resolvers(4'd1);
        repeat (5) send(CMD_TICK, 16'h0, 16'h0, 16'h0, 16'h0);
        drain();
        set_resolvers(4'd15);

        // Random phases with differing gap rates and resolver counts.
        tx_idle_pct = 13; rx_idle_pct = 50;
        for (int i = 0; i < 150; i++)
        begin
            random_request();
            if (i == 80)
                drain();    // sender holds off until the table has answered
        end
        drain();
        set_resolvers(4'd3);
        tx_idle_pct = 50; rx_idle_pct = 13;
        for (int i = 0; i < 150; i++) random_request();
        drain();
        set_resolvers(4'd0);
        tx_idle_pct = 0; rx_idle_pct = 0;
        for (int i = 0; i < 20; i++) random_request();
        drain();
        set_resolvers(4'd8);
        for (int i = 0; i < 120; i++) random_request();

        drain();
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("Verification failed");
        $finish;
    end
endmodule

[sim.f]
+incdir+rtl
rtl/qrt_pkg.sv
rtl/qrt_if.sv
rtl/qrt_mem.sv
rtl/query_id_remap_timeout_table_unit.sv
verif/qrt_checker.sv
verif/tb_top.sv
